/* design/itb_pkg.sv */
// Shared types, constants and helpers for the IMU tilt and rate block.
package itb_pkg;

  localparam int CNT_W      = 7;
  localparam int CORD_STEPS = 16;

  localparam logic [1:0] PH_DISCARD = 2'd0;
  localparam logic [1:0] PH_AVERAGE = 2'd1;
  localparam logic [1:0] PH_RUN     = 2'd2;

  localparam logic signed [16:0] ANGLE_LIM     = 17'sd11520;
  localparam logic signed [16:0] ANGLE_OUT_LIM = 17'sd23040;
  localparam logic signed [16:0] RATE_OUT_LIM  = 17'sd32000;

  localparam logic [32:0] RATE_RECIP   = 33'(((64'd1 << 33) + 64'd261) / 64'd262);
  localparam logic [25:0] RATE_ROUND   = 26'd131;
  localparam logic [25:0] QUO_BIAS_262 = 26'd8585216;
  localparam logic [15:0] QUO_BIAS     = 16'h8000;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               restart_calibration;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] z_tilt_angle;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic               calibrated;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [32:0] recip;
  } div_req_t;

  function automatic logic signed [23:0] atan_entry(input logic [3:0] i);
    logic signed [23:0] t;
    case (i)
      4'd0:    t = 24'sd1474560;
      4'd1:    t = 24'sd870484;
      4'd2:    t = 24'sd459940;
      4'd3:    t = 24'sd233473;
      4'd4:    t = 24'sd117189;
      4'd5:    t = 24'sd58652;
      4'd6:    t = 24'sd29333;
      4'd7:    t = 24'sd14667;
      4'd8:    t = 24'sd7334;
      4'd9:    t = 24'sd3667;
      4'd10:   t = 24'sd1833;
      4'd11:   t = 24'sd917;
      4'd12:   t = 24'sd458;
      4'd13:   t = 24'sd229;
      4'd14:   t = 24'sd115;
      default: t = 24'sd57;
    endcase
    return t;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v,
                                               input logic signed [16:0] lim);
    logic signed [16:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r[15:0];
  endfunction

endpackage

/* design/itb_div.sv */
// Constant-divisor unit: latch a dividend and its reciprocal, then multiply and shift.
module itb_div (
  input  logic              clk,
  input  logic              rst,
  input  itb_pkg::div_req_t req,
  output logic              done,
  output logic [15:0]       quo
);

  logic [23:0] num;
  logic [32:0] recip;
  logic [56:0] prod;
  logic        busy;

  assign prod = {33'b0, num} * {24'b0, recip};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num   <= req.dividend;
        recip <= req.recip;
        busy  <= 1'b1;
      end else if (busy) begin
        quo  <= prod[48:33];
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

/* design/imu_tilt_angles_with_bias_calibration.sv */
// Tilt angles and bias-removed rates from accelerometer and gyro samples.
// One item is taken at a time; sample_stall stays high from acceptance until
// its result is loaded into the output register. Each of the three tilts uses
// two squares on one shared multiplier, a check, a 24-step square root and 16
// CORDIC steps, and stops at the check when its numerator or denominator is
// zero; the three rates then take one division each on a reciprocal-multiply
// divider, and the result is staged and loaded into the output register. The
// item that ends averaging adds six offset divisions, and a result still stalled
// at the output holds the block until it is taken. The first DISCARD_SAMPLES
// items after reset or restart are dropped and the next CAL_SAMPLES are
// averaged; meanwhile calibrated is 0 and all other fields are 0.
module imu_tilt_angles_with_bias_calibration #(
  parameter int DISCARD_SAMPLES = 10,
  parameter int CAL_SAMPLES     = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  itb_pkg::in_item_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output itb_pkg::out_item_t result
);
  import itb_pkg::*;

  localparam logic [8:0]  AVG_DIVISOR = 9'(2 * CAL_SAMPLES);
  localparam logic [32:0] AVG_RECIP   =
    33'(((64'd1 << 33) + 64'(AVG_DIVISOR) - 64'd1) / 64'(AVG_DIVISOR));
  localparam logic [25:0] AVG_BIAS    = 26'(2 * CAL_SAMPLES * 32768);
  localparam logic [1:0]  PH_START    = (DISCARD_SAMPLES == 0) ? PH_AVERAGE : PH_DISCARD;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SQB  = 11'b00000000010,
    S_SQC  = 11'b00000000100,
    S_CHK  = 11'b00000001000,
    S_SQRT = 11'b00000010000,
    S_CORD = 11'b00000100000,
    S_ANG  = 11'b00001000000,
    S_RATE = 11'b00010000000,
    S_FIN  = 11'b00100000000,
    S_AVG  = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t             state;
  in_item_t           item;
  out_item_t          held;
  logic [1:0]         phase;
  logic [CNT_W-1:0]   cnt;
  logic [1:0]         k;
  logic [2:0]         j;
  logic signed [21:0] asum [3];
  logic signed [21:0] rsum [3];
  logic signed [15:0] aoff [3];
  logic signed [15:0] roff [3];
  logic signed [15:0] ang [3];
  logic signed [15:0] rt [3];
  logic [30:0]        sq;
  logic [31:0]        sqsum;
  logic [47:0]        v;
  logic [47:0]        root;
  logic [47:0]        sbit;
  logic signed [27:0] cx;
  logic signed [27:0] cy;
  logic signed [23:0] cz;
  logic [3:0]         ci;
  logic               div_run;

  logic signed [16:0] ta;
  logic signed [15:0] tb;
  logic signed [15:0] tc;
  logic signed [15:0] graw;
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_prod;
  logic [47:0]        trial;
  logic               ge;
  logic [47:0]        root_next;
  logic signed [27:0] dx;
  logic signed [27:0] dy;
  logic signed [23:0] zr;
  logic signed [16:0] ang_raw;
  logic signed [21:0] avg_sum;
  logic [25:0]        rate_num;
  logic [25:0]        avg_num;
  logic [CNT_W-1:0]   cnt_inc;
  div_req_t           dreq;
  logic               div_done;
  logic [15:0]        quo;
  logic signed [15:0] quo_s;

  always_comb begin
    case (k)
      2'd0: begin
        ta = 17'(item.accel_y); tb = item.accel_x; tc = item.accel_z; graw = item.gyro_x;
      end
      2'd1: begin
        ta = -17'(item.accel_x); tb = item.accel_y; tc = item.accel_z; graw = item.gyro_y;
      end
      default: begin
        ta = 17'(item.accel_z); tb = item.accel_x; tc = item.accel_y; graw = item.gyro_z;
      end
    endcase
  end

  assign sq_op     = (state == S_SQC) ? tc : tb;
  assign sq_prod   = sq_op * sq_op;
  assign trial     = root + sbit;
  assign ge        = (v >= trial);
  assign root_next = ge ? ((root >> 1) + sbit) : (root >> 1);
  assign dx        = cy >>> ci;
  assign dy        = cx >>> ci;
  assign zr        = cz + 24'sd128;
  assign ang_raw   = 17'(zr >>> 8);
  assign cnt_inc   = cnt + 7'd1;
  assign avg_sum   = (j < 3'd3) ? asum[j[1:0]] : rsum[2'(j - 3'd3)];
  assign rate_num  = {{3{graw[15]}}, graw, 7'b0} + RATE_ROUND + QUO_BIAS_262;
  assign avg_num   = {{3{avg_sum[21]}}, avg_sum, 1'b0} + 26'(CAL_SAMPLES) + AVG_BIAS;
  assign quo_s     = quo ^ QUO_BIAS;

  assign dreq.start    = (state == S_RATE || state == S_AVG) && !div_run;
  assign dreq.dividend = (state == S_RATE) ? rate_num[23:0] : avg_num[23:0];
  assign dreq.recip    = (state == S_RATE) ? RATE_RECIP : AVG_RECIP;

  itb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quo  (quo)
  );

  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_START;
      cnt          <= '0;
      k            <= '0;
      j            <= '0;
      div_run      <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        asum[i] <= '0;
        rsum[i] <= '0;
        aoff[i] <= '0;
        roff[i] <= '0;
      end
    end else begin
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            item  <= sample;
            k     <= '0;
            state <= S_SQB;
            if (sample.restart_calibration) begin
              phase <= PH_START;
              cnt   <= '0;
              for (int i = 0; i < 3; i++) begin
                asum[i] <= '0;
                rsum[i] <= '0;
                aoff[i] <= '0;
                roff[i] <= '0;
              end
            end
          end
        end
        S_SQB: begin
          sq    <= sq_prod[30:0];
          state <= S_SQC;
        end
        S_SQC: begin
          sqsum <= {1'b0, sq} + {1'b0, sq_prod[30:0]};
          state <= S_CHK;
        end
        S_CHK: begin
          if (ta == 17'sd0 || sqsum == 32'd0) begin
            if (ta == 17'sd0) ang[k] <= '0;
            else ang[k] <= ta[16] ? -ANGLE_LIM[15:0] : ANGLE_LIM[15:0];
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_RATE;
            end else begin
              k     <= k + 2'd1;
              state <= S_SQB;
            end
          end else begin
            v     <= {sqsum, 16'b0};
            root  <= '0;
            sbit  <= 48'h4000_0000_0000;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ge) v <= v - trial;
          root <= root_next;
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            cx    <= 28'(root_next);
            cy    <= {{3{ta[16]}}, ta, 8'b0};
            cz    <= '0;
            ci    <= '0;
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (!cy[27] && cy != 28'sd0) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + atan_entry(ci);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - atan_entry(ci);
          end
          ci <= ci + 4'd1;
          if (ci == 4'(CORD_STEPS - 1)) state <= S_ANG;
        end
        S_ANG: begin
          ang[k] <= sat16(ang_raw, ANGLE_LIM);
          if (k == 2'd2) begin
            k     <= '0;
            state <= S_RATE;
          end else begin
            k     <= k + 2'd1;
            state <= S_SQB;
          end
        end
        S_RATE: begin
          if (!div_run) div_run <= 1'b1;
          if (div_done) begin
            rt[k]   <= quo_s;
            div_run <= 1'b0;
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_FIN;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_FIN: begin
          case (phase)
            PH_DISCARD: begin
              held  <= '0;
              state <= S_DONE;
              if (cnt_inc >= CNT_W'(DISCARD_SAMPLES)) begin
                cnt   <= '0;
                phase <= PH_AVERAGE;
              end else begin
                cnt <= cnt_inc;
              end
            end
            PH_AVERAGE: begin
              held <= '0;
              for (int i = 0; i < 3; i++) begin
                asum[i] <= asum[i] + 22'(ang[i]);
                rsum[i] <= rsum[i] + 22'(rt[i]);
              end
              if (cnt_inc >= CNT_W'(CAL_SAMPLES)) begin
                cnt   <= '0;
                phase <= PH_RUN;
                j     <= '0;
                state <= S_AVG;
              end else begin
                cnt   <= cnt_inc;
                state <= S_DONE;
              end
            end
            default: begin
              held.roll_angle   <= sat16(17'(ang[0]) - 17'(aoff[0]), ANGLE_OUT_LIM);
              held.pitch_angle  <= sat16(17'(ang[1]) - 17'(aoff[1]), ANGLE_OUT_LIM);
              held.z_tilt_angle <= sat16(17'(ang[2]) - 17'(aoff[2]), ANGLE_OUT_LIM);
              held.roll_rate    <= sat16(17'(rt[0]) - 17'(roff[0]), RATE_OUT_LIM);
              held.pitch_rate   <= sat16(17'(rt[1]) - 17'(roff[1]), RATE_OUT_LIM);
              held.yaw_rate     <= sat16(17'(rt[2]) - 17'(roff[2]), RATE_OUT_LIM);
              held.calibrated   <= 1'b1;
              state             <= S_DONE;
            end
          endcase
        end
        S_AVG: begin
          if (!div_run) div_run <= 1'b1;
          if (div_done) begin
            div_run <= 1'b0;
            if (j < 3'd3) aoff[j[1:0]] <= quo_s;
            else roff[2'(j - 3'd3)] <= quo_s;
            if (j == 3'd5) state <= S_DONE;
            else j <= j + 3'd1;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= held;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/itb_chk.sv */
// Port-level checker for the IMU tilt and rate block, with its bind.
module itb_chk (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input itb_pkg::in_item_t  sample,
  input logic               result_valid,
  input logic               result_stall,
  input itb_pkg::out_item_t result
);
  import itb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("new item taken while one is in progress");

  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.calibrated |->
      result.roll_angle == 16'sd0 && result.pitch_angle == 16'sd0 &&
      result.z_tilt_angle == 16'sd0 && result.roll_rate == 16'sd0 &&
      result.pitch_rate == 16'sd0 && result.yaw_rate == 16'sd0)
    else $error("nonzero field during calibration");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      result.roll_angle >= -16'sd23040 && result.roll_angle <= 16'sd23040 &&
      result.pitch_angle >= -16'sd23040 && result.pitch_angle <= 16'sd23040 &&
      result.z_tilt_angle >= -16'sd23040 && result.z_tilt_angle <= 16'sd23040 &&
      result.roll_rate >= -16'sd32000 && result.roll_rate <= 16'sd32000 &&
      result.pitch_rate >= -16'sd32000 && result.pitch_rate <= 16'sd32000 &&
      result.yaw_rate >= -16'sd32000 && result.yaw_rate <= 16'sd32000)
    else $error("result field out of range");

endmodule

bind imu_tilt_angles_with_bias_calibration itb_chk u_itb_chk (.*);
